### rtl/polar_line_intersection_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polar line intersection block
// Concurrent checks clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLAR_LINE_INTERSECTION_MACROS_SVH
`define POLAR_LINE_INTERSECTION_MACROS_SVH

// cons must hold in the cycle after trig
`define PLI_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

// cons must hold in the same cycle as trig
`define PLI_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

### rtl/plint_pkg.sv
// ----------------------------------------------------------------------------
// Polar line intersection package
// Shared formats, angle constants, arctangent table and queue beat type.
// ----------------------------------------------------------------------------
package plint_pkg;

    // angle format: signed, ANGLE_FRAC_BITS fraction bits
    localparam int ANGLE_FRAC_BITS = 28;
    localparam int ANG_W           = 34;
    localparam int Z_W             = 32;
    localparam int Z_SHIFT         = 30 - ANGLE_FRAC_BITS;

    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] PI_U =
        (PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
    localparam logic [63:0] TWO_PI_U =
        (PI_Q61 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI_U =
        (PI_Q61 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);

    localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(PI_U);
    localparam logic signed [ANG_W-1:0] TWO_PI_A  = ANG_W'(TWO_PI_U);
    localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(HALF_PI_U);
    localparam logic signed [ANG_W-1:0] TWO_PI_MINUS_HALF = TWO_PI_A - HALF_PI_A;

    // parallel tolerance register
    localparam int TOL_W = 28;
    localparam logic [TOL_W-1:0] TOL_RESET = 28'd26844;

    // CORDIC datapath, Q30
    localparam int XY_W = 34;
    localparam int CZ_W = 33;
    localparam int CS_W = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // quotient and result format
    localparam int OUT_W      = 48;
    localparam int QUOT_SHIFT = 38;
    localparam int DIV_STEPS  = OUT_W;
    localparam int DIV_LOW    = DIV_STEPS - QUOT_SHIFT;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam logic [OUT_W-1:0] OUT_MAX_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MAX_NEG = 48'h8000_0000_0000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic signed [31:0]    rho_first;
        logic signed [31:0]    rho_second;
        logic signed [Z_W-1:0] z_first;
        logic signed [Z_W-1:0] z_second;
        logic                  neg_first;
        logic                  neg_second;
        logic                  par;
    } item_t;

    // atan(2^-idx) in Q30
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: v = (idx < 30) ? (32'd1 << (30 - idx)) : 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/polar_line_intersection.sv
// ----------------------------------------------------------------------------
// Polar line intersection
// Takes two lines in Hesse normal form (rho Q8.24, theta Q4.28) and returns
// their crossing point (x, y) in Q16.32. One line pair is accepted per clock
// when the result side keeps up; a pair passes the CORDIC stage chain and the
// 48 single-bit quotient stages. The front end runs the parallel test (angle
// difference within parallel_tolerance of 0, pi or 2pi) and folds both angles
// into [-pi/2, pi/2]; a four-beat queue lets it keep taking pairs while the
// back end is held by a stalled output. Parallel lines, and pairs whose
// determinant is exactly zero, give lines_parallel = 1 with zero coordinates.
// A coordinate beyond the 48-bit range is clamped and result_saturated is set.
// parallel_tolerance is to be written through cfg_wr_en / cfg_wr_data while
// idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module polar_line_intersection
    import plint_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_wr_en,
    input  logic [TOL_W-1:0]        cfg_wr_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      rho_first,
    input  logic signed [31:0]      theta_first,
    input  logic signed [31:0]      rho_second,
    input  logic signed [31:0]      theta_second,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] x_coord,
    output logic signed [OUT_W-1:0] y_coord,
    output logic                    lines_parallel,
    output logic                    result_saturated
);

    // parallel test tolerance, units of 2^-28 rad
    logic [TOL_W-1:0] tolerance_reg;

    logic  push, queue_full, pop, not_empty;
    item_t push_item, head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tolerance_reg <= cfg_wr_data;
        end
    end

    // classify and fold angles
    plint_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rho_first    (rho_first),
        .theta_first  (theta_first),
        .rho_second   (rho_second),
        .theta_second (theta_second),
        .tolerance    (tolerance_reg),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    // decouples front stalls from back stalls
    plint_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty)
    );

    // trig, products, quotients, clamp, output register
    plint_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_item        (head_item),
        .not_empty        (not_empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .lines_parallel   (lines_parallel),
        .result_saturated (result_saturated)
    );

endmodule

### rtl/plint_front.sv
// ----------------------------------------------------------------------------
// Front end
// Takes line pairs, runs the parallel test and folds both angles into [-pi/2,
// pi/2] for the CORDIC. Three stages, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module plint_front
    import plint_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      rho_first,
    input  logic signed [31:0]      theta_first,
    input  logic signed [31:0]      rho_second,
    input  logic signed [31:0]      theta_second,
    input  logic [TOL_W-1:0]        tolerance,
    output logic                    push,
    output item_t                   push_item,
    input  logic                    queue_full
);

    logic [2:0] vld_reg;
    logic       adv;

    logic signed [31:0]      rho_f_a_reg, rho_s_a_reg, rho_f_b_reg, rho_s_b_reg;
    logic signed [ANG_W-1:0] t1_f_a_reg, t1_s_a_reg, adiff_a_reg;
    logic signed [ANG_W-1:0] r2_f_b_reg, r2_s_b_reg;
    logic                    par_b_reg;
    item_t                   item_c_reg;

    logic signed [ANG_W-1:0] tol_ext, diff_a;
    logic [Z_W:0]            red_f, red_s;

    function automatic logic signed [ANG_W-1:0] ext_ang(input logic signed [31:0] t);
        return {{(ANG_W-32){t[31]}}, t};
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_lo(input logic signed [31:0] t);
        logic signed [ANG_W-1:0] e;
        e = ext_ang(t);
        return (e < 0) ? e + TWO_PI_A : e;
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_hi(input logic signed [ANG_W-1:0] t);
        logic signed [ANG_W-1:0] r;
        if (t < 0)
        begin
            r = t + TWO_PI_A;
        end
        else if (t >= TWO_PI_A)
        begin
            r = t - TWO_PI_A;
        end
        else
        begin
            r = t;
        end
        return r;
    endfunction

    function automatic logic near(input logic signed [ANG_W-1:0] a,
                                  input logic signed [ANG_W-1:0] b,
                                  input logic signed [ANG_W-1:0] tol);
        logic signed [ANG_W-1:0] d;
        d = a - b;
        if (d < 0)
        begin
            d = -d;
        end
        return d < tol;
    endfunction

    // {neg, z in Q30}
    function automatic logic [Z_W:0] reduce_angle(input logic signed [ANG_W-1:0] r2);
        logic signed [ANG_W-1:0] r, rs;
        logic                    neg;
        neg = (r2 > HALF_PI_A) && (r2 < TWO_PI_MINUS_HALF);
        if (neg)
        begin
            // above pi the angle is first taken down by 2pi, then up by pi
            if (r2 > PI_A)
            begin
                r = r2 - TWO_PI_A + PI_A;
            end
            else
            begin
                r = r2 - PI_A;
            end
        end
        else if (r2 > HALF_PI_A)
        begin
            r = r2 - TWO_PI_A;
        end
        else
        begin
            r = r2;
        end
        rs = r <<< Z_SHIFT;
        return {neg, rs[Z_W-1:0]};
    endfunction

    assign adv      = !(vld_reg[2] && queue_full);
    assign in_stall = !adv;
    assign push     = vld_reg[2] && !queue_full;
    assign push_item = item_c_reg;

    assign tol_ext = {{(ANG_W-TOL_W){1'b0}}, tolerance};
    assign diff_a  = ext_ang(theta_second) - ext_ang(theta_first);
    assign red_f   = reduce_angle(r2_f_b_reg);
    assign red_s   = reduce_angle(r2_s_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rho_f_a_reg <= rho_first;
            rho_s_a_reg <= rho_second;
            t1_f_a_reg  <= wrap_lo(theta_first);
            t1_s_a_reg  <= wrap_lo(theta_second);
            adiff_a_reg <= (diff_a < 0) ? -diff_a : diff_a;

            rho_f_b_reg <= rho_f_a_reg;
            rho_s_b_reg <= rho_s_a_reg;
            r2_f_b_reg  <= wrap_hi(t1_f_a_reg);
            r2_s_b_reg  <= wrap_hi(t1_s_a_reg);
            par_b_reg   <= (adiff_a_reg < tol_ext)
                        || near(adiff_a_reg, PI_A, tol_ext)
                        || near(adiff_a_reg, TWO_PI_A, tol_ext);

            item_c_reg.rho_first  <= rho_f_b_reg;
            item_c_reg.rho_second <= rho_s_b_reg;
            item_c_reg.z_first    <= red_f[Z_W-1:0];
            item_c_reg.z_second   <= red_s[Z_W-1:0];
            item_c_reg.neg_first  <= red_f[Z_W];
            item_c_reg.neg_second <= red_s[Z_W];
            item_c_reg.par        <= par_b_reg;
        end
    end

endmodule

### rtl/plint_fifo.sv
// ----------------------------------------------------------------------------
// Front-to-back queue
// Small register queue; head is read straight out of the entry array.
// ----------------------------------------------------------------------------
module plint_fifo
    import plint_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head_item,
    output logic  not_empty
);

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/plint_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// Rotation mode, one micro-rotation per stage, then quadrant sign fix.
// ----------------------------------------------------------------------------
module plint_cordic
    import plint_pkg::*;
#(
    parameter int ITERATIONS = 24
)
(
    input  logic                   clk,
    input  logic                   adv,
    input  logic signed [Z_W-1:0]  z_in,
    input  logic                   neg_in,
    output logic signed [CS_W-1:0] cos_out,
    output logic signed [CS_W-1:0] sin_out
);

    logic signed [XY_W-1:0] x_reg [1:ITERATIONS];
    logic signed [XY_W-1:0] y_reg [1:ITERATIONS];
    logic signed [CZ_W-1:0] z_reg [1:ITERATIONS];
    logic                   neg_reg [1:ITERATIONS];
    logic signed [CS_W-1:0] cos_reg, sin_reg;
    logic signed [XY_W-1:0] x_fin, y_fin;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_stage
        logic signed [XY_W-1:0] xi, yi;
        logic signed [CZ_W-1:0] zi, at;
        logic                   ni;

        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN;
            assign yi = '0;
            assign zi = {z_in[Z_W-1], z_in};
            assign ni = neg_in;
        end
        else
        begin : g_rest
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign ni = neg_reg[i];
        end

        assign at = $signed({1'b0, atan_q30(i)});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!zi[CZ_W-1])
                begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - at;
                end
                else
                begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + at;
                end
                neg_reg[i+1] <= ni;
            end
        end
    end

    assign x_fin = neg_reg[ITERATIONS] ? -x_reg[ITERATIONS] : x_reg[ITERATIONS];
    assign y_fin = neg_reg[ITERATIONS] ? -y_reg[ITERATIONS] : y_reg[ITERATIONS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= x_fin[CS_W-1:0];
            sin_reg <= y_fin[CS_W-1:0];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

### rtl/plint_div.sv
// ----------------------------------------------------------------------------
// Pipelined quotient unit
// floor(n * 2^38 / d) as 48 bits, one restoring step per stage, plus an
// overflow flag when the quotient needs more than 48 bits.
// ----------------------------------------------------------------------------
module plint_div
    import plint_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic [63:0]      num,
    input  logic [63:0]      den,
    output logic [OUT_W-1:0] quot,
    output logic             ovf
);

    logic [63:0]        rem_reg [0:DIV_STEPS];
    logic [63:0]        den_reg [0:DIV_STEPS];
    logic [DIV_LOW-1:0] low_reg [0:DIV_STEPS];
    logic [OUT_W-1:0]   q_reg   [0:DIV_STEPS];
    logic               ovf_reg [0:DIV_STEPS];
    logic [63:0]        num_hi;

    assign num_hi = {{DIV_LOW{1'b0}}, num[63:DIV_LOW]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num_hi;
            den_reg[0] <= den;
            low_reg[0] <= num[DIV_LOW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_hi >= den);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [64:0] sh, trial;
        assign sh    = {rem_reg[k], low_reg[k][DIV_LOW-1]};
        assign trial = sh - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sh >= {1'b0, den_reg[k]})
                begin
                    rem_reg[k+1] <= trial[63:0];
                    q_reg[k+1]   <= {q_reg[k][OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= sh[63:0];
                    q_reg[k+1]   <= {q_reg[k][OUT_W-2:0], 1'b0};
                end
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= {low_reg[k][DIV_LOW-2:0], 1'b0};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quot = q_reg[DIV_STEPS];
    assign ovf  = ovf_reg[DIV_STEPS];

endmodule

### rtl/plint_back.sv
// ----------------------------------------------------------------------------
// Back end
// Cosine/sine of both angles, cross products, determinant, two quotients,
// clamping and the output register. Whole pipe moves on one advance.
// ----------------------------------------------------------------------------
module plint_back
    import plint_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  item_t                   head_item,
    input  logic                    not_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] x_coord,
    output logic signed [OUT_W-1:0] y_coord,
    output logic                    lines_parallel,
    output logic                    result_saturated
);

    localparam int CORDIC_LAT = CORDIC_ITERATIONS + 1;
    localparam int PIPE_LAT   = CORDIC_LAT + 3 + DIV_LAT;

    typedef struct packed {
        logic signed [31:0] rho_first;
        logic signed [31:0] rho_second;
        logic               par;
    } side_a_t;

    typedef struct packed {
        logic par;
        logic neg_x;
        logic neg_y;
    } side_b_t;

    logic adv;
    logic [PIPE_LAT-1:0] vld_reg;

    side_a_t side_a_reg [CORDIC_LAT];
    side_b_t side_b_reg [DIV_LAT];
    side_a_t side_a_in, side_a_out;
    side_b_t side_b_out;

    logic signed [CS_W-1:0] cl, sl, cr, sr;

    logic signed [64:0] p_yr_reg, p_yl_reg, p_xr_reg, p_xl_reg;
    logic signed [65:0] p_d1_reg, p_d2_reg;
    logic               par_p_reg, par_n_reg;
    logic signed [65:0] num_y_reg, num_x_reg;
    logic signed [66:0] det_reg;

    logic [63:0] n_y_reg, n_x_reg, d_reg;
    side_b_t     side_m_reg;

    logic [OUT_W-1:0] q_x, q_y;
    logic             ovf_x, ovf_y;
    logic [OUT_W:0]   fin_x, fin_y;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] x_reg, y_reg;
    logic                    par_reg, sat_reg;

    function automatic logic signed [64:0] mul_rc(input logic signed [31:0] a,
                                                  input logic signed [CS_W-1:0] b);
        logic signed [64:0] ae, be;
        ae = {{33{a[31]}}, a};
        be = {{(65-CS_W){b[CS_W-1]}}, b};
        return ae * be;
    endfunction

    function automatic logic signed [65:0] mul_cc(input logic signed [CS_W-1:0] a,
                                                  input logic signed [CS_W-1:0] b);
        logic signed [65:0] ae, be;
        ae = {{(66-CS_W){a[CS_W-1]}}, a};
        be = {{(66-CS_W){b[CS_W-1]}}, b};
        return ae * be;
    endfunction

    function automatic logic [63:0] mag67(input logic signed [66:0] v);
        logic signed [66:0] m;
        m = v[66] ? -v : v;
        return m[63:0];
    endfunction

    // {saturated, value}
    function automatic logic [OUT_W:0] finish(input logic [OUT_W-1:0] q,
                                              input logic ov, input logic neg);
        logic [OUT_W-1:0] cap;
        logic             sat;
        cap = neg ? OUT_MAX_NEG : OUT_MAX_POS;
        sat = ov || (q > cap);
        return {sat, sat ? cap : (neg ? -q : q)};
    endfunction

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && not_empty;

    assign side_a_in.rho_first  = head_item.rho_first;
    assign side_a_in.rho_second = head_item.rho_second;
    assign side_a_in.par        = head_item.par;
    assign side_a_out = side_a_reg[CORDIC_LAT-1];
    assign side_b_out = side_b_reg[DIV_LAT-1];

    plint_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_first (
        .clk     (clk),
        .adv     (adv),
        .z_in    (head_item.z_first),
        .neg_in  (head_item.neg_first),
        .cos_out (cl),
        .sin_out (sl)
    );

    plint_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_second (
        .clk     (clk),
        .adv     (adv),
        .z_in    (head_item.z_second),
        .neg_in  (head_item.neg_second),
        .cos_out (cr),
        .sin_out (sr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_LAT-2:0], pop};
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg[0] <= side_a_in;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                side_a_reg[k] <= side_a_reg[k-1];
            end

            // products (Q54 numerator terms, Q60 determinant terms)
            p_yr_reg  <= mul_rc(side_a_out.rho_second, cl);
            p_yl_reg  <= mul_rc(side_a_out.rho_first,  cr);
            p_xr_reg  <= mul_rc(side_a_out.rho_second, sl);
            p_xl_reg  <= mul_rc(side_a_out.rho_first,  sr);
            p_d1_reg  <= mul_cc(sr, cl);
            p_d2_reg  <= mul_cc(sl, cr);
            par_p_reg <= side_a_out.par;

            num_y_reg <= {p_yr_reg[64], p_yr_reg} - {p_yl_reg[64], p_yl_reg};
            num_x_reg <= {p_xr_reg[64], p_xr_reg} - {p_xl_reg[64], p_xl_reg};
            det_reg   <= {p_d1_reg[65], p_d1_reg} - {p_d2_reg[65], p_d2_reg};
            par_n_reg <= par_p_reg;

            n_y_reg <= mag67({num_y_reg[65], num_y_reg});
            n_x_reg <= mag67({num_x_reg[65], num_x_reg});
            d_reg   <= mag67(det_reg);
            side_m_reg.par   <= par_n_reg || (det_reg == '0);
            side_m_reg.neg_y <= (num_y_reg != '0) && (num_y_reg[65] != det_reg[66]);
            // x divides by -det
            side_m_reg.neg_x <= (num_x_reg != '0) && (num_x_reg[65] == det_reg[66]);

            side_b_reg[0] <= side_m_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    plint_div u_div_x (
        .clk  (clk),
        .adv  (adv),
        .num  (n_x_reg),
        .den  (d_reg),
        .quot (q_x),
        .ovf  (ovf_x)
    );

    plint_div u_div_y (
        .clk  (clk),
        .adv  (adv),
        .num  (n_y_reg),
        .den  (d_reg),
        .quot (q_y),
        .ovf  (ovf_y)
    );

    assign fin_x = finish(q_x, ovf_x, side_b_out.neg_x);
    assign fin_y = finish(q_y, ovf_y, side_b_out.neg_y);

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[PIPE_LAT-1])
        begin
            par_reg <= side_b_out.par;
            if (side_b_out.par)
            begin
                x_reg   <= '0;
                y_reg   <= '0;
                sat_reg <= 1'b0;
            end
            else
            begin
                x_reg   <= fin_x[OUT_W-1:0];
                y_reg   <= fin_y[OUT_W-1:0];
                sat_reg <= fin_x[OUT_W] || fin_y[OUT_W];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign x_coord          = x_reg;
    assign y_coord          = y_reg;
    assign lines_parallel   = par_reg;
    assign result_saturated = sat_reg;

endmodule

### rtl/plint_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the result side of the block; attached by bind.
// ----------------------------------------------------------------------------
`include "polar_line_intersection_macros.svh"

module plint_checker
    import plint_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] x_coord,
    input logic signed [OUT_W-1:0] y_coord,
    input logic                    lines_parallel,
    input logic                    result_saturated
);

    `PLI_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid, "result beat dropped while stalled")

    `PLI_ASSERT_NEXT(a_beat_holds, out_valid && out_stall, $stable(x_coord) && $stable(y_coord) && $stable(lines_parallel) && $stable(result_saturated), "result beat changed while stalled")

    `PLI_ASSERT_SAME(a_parallel_zero, out_valid && lines_parallel, x_coord == '0 && y_coord == '0 && !result_saturated, "parallel beat not zeroed")

    `PLI_ASSERT_SAME(a_sat_clamped, out_valid && result_saturated, x_coord == OUT_MAX_POS || x_coord == OUT_MAX_NEG || y_coord == OUT_MAX_POS || y_coord == OUT_MAX_NEG, "saturated beat without clamp value")

endmodule

bind polar_line_intersection plint_checker u_checker (.*);

### dv/polar_line_intersection_tb.sv
// ----------------------------------------------------------------------------
// Polar line intersection testbench
// Drives line pairs through the valid/stall channel and checks every result
// beat against a bit-accurate fixed-point model of the CORDIC and divider
// path. A directed table covers the parallel, exact-tolerance and extreme
// cases. It is followed by random phases at several tolerance settings and
// idle patterns.
// ----------------------------------------------------------------------------
module polar_line_intersection_tb;
    import plint_pkg::*;

    localparam int  N_ITER       = 24;
    localparam int  LIMIT_CYCLES = 600000;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  N_PHASE      = 4;

    localparam longint PI_L   = longint'(PI_A);
    localparam longint TWO_L  = longint'(TWO_PI_A);
    localparam longint HALF_L = longint'(HALF_PI_A);

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    par;
        logic                    sat;
    } point_t;

    typedef struct {
        logic signed [31:0] rho1;
        logic signed [31:0] th1;
        logic signed [31:0] rho2;
        logic signed [31:0] th2;
        bit                 typed;   // expected result written in the row
        point_t             want;
    } row_t;

    // atan(2^-i), Q30
    localparam longint ATAN_TAB [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [TOL_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] rho_first, theta_first, rho_second, theta_second;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] x_coord, y_coord;
    logic lines_parallel, result_saturated;

    polar_line_intersection u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rho_first        (rho_first),
        .theta_first      (theta_first),
        .rho_second       (rho_second),
        .theta_second     (theta_second),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .lines_parallel   (lines_parallel),
        .result_saturated (result_saturated)
    );

    always #10 clk = ~clk;

    // Model copy of the tolerance register
    longint tol_model = longint'(TOL_RESET);

    point_t pending_points[$];
    int     err_count;
    int     beats_in, beats_out, n_par, n_sat;
    int     snd_idle, rcv_idle;
    longint cycles;

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // cos/sin in Q30 after folding the angle into [-pi/2, pi/2]
    function automatic void cordic_cos_sin(input longint ang, output longint c,
                                           output longint s);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r    = ang % TWO_L;
        flip = 0;
        if (r < 0) r += TWO_L;
        if (r > PI_L) r -= TWO_L;
        if (r > HALF_L)
        begin
            r -= PI_L;
            flip = 1;
        end
        else if (r < -HALF_L)
        begin
            r += PI_L;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = r * (longint'(1) << (30 - ANGLE_FRAC_BITS));
        for (int i = 0; i < N_ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_TAB[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Q54 / Q60 -> Q16.32, truncated on magnitudes, clamped to 48 bits
    function automatic longint clamp_divide(input longint num, input longint den,
                                            inout logic sat);
        longint unsigned n, d, q, r, cap;
        bit neg;
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        neg = (num != 0) && ((num < 0) != (den < 0));
        cap = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        q   = n / d;
        r   = n % d;
        for (int k = 0; k < QUOT_SHIFT && q <= cap; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r -= d;
                q |= 1;
            end
        end
        if (q > cap)
        begin
            q   = cap;
            sat = 1'b1;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit within_tol(input longint a, input longint b, input longint tol);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return d < tol;
    endfunction

    function automatic point_t intersect_lines(input logic signed [31:0] rho1,
                                               input logic signed [31:0] th1,
                                               input logic signed [31:0] rho2,
                                               input logic signed [31:0] th2);
        point_t p;
        longint diff, c1, s1, c2, s2, det, rl, rr;
        p.x   = '0;
        p.y   = '0;
        p.sat = 1'b0;
        rl    = rho1;
        rr    = rho2;
        diff  = longint'(th2) - longint'(th1);
        if (diff < 0) diff = -diff;
        p.par = diff < tol_model || within_tol(diff, PI_L, tol_model)
                || within_tol(diff, TWO_L, tol_model);
        if (!p.par)
        begin
            cordic_cos_sin(th1, c1, s1);
            cordic_cos_sin(th2, c2, s2);
            det = s2 * c1 - s1 * c2;
            if (det == 0)
                p.par = 1'b1;
            else
            begin
                p.y = OUT_W'(clamp_divide(rr * c1 - rl * c2, det, p.sat));
                p.x = OUT_W'(clamp_divide(rr * s1 - rl * s2, -det, p.sat));
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // One beat: random gaps first, then hold the pair until it is taken.
    task automatic send_pair(input row_t r);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        rho_first    <= r.rho1;
        theta_first  <= r.th1;
        rho_second   <= r.rho2;
        theta_second <= r.th2;
        do @(posedge clk); while (in_stall);
        pending_points.push_back(r.typed ? r.want
                                 : intersect_lines(r.rho1, r.th1, r.rho2, r.th2));
        beats_in++;
    endtask

    // Random pair, shaped so that near-parallel and saturating pairs show up
    function automatic row_t random_pair();
        row_t   r;
        int     kind;
        longint off;
        r.typed = 0;
        r.rho1  = $urandom;
        r.rho2  = $urandom;
        r.th1   = $urandom;
        r.th2   = $urandom;
        kind    = $urandom_range(9);
        if (kind >= 3 && kind <= 6)
        begin
            r.th1 = 32'(longint'($urandom_range(32'(2 * TWO_L))) - TWO_L);
            r.th2 = 32'(longint'($urandom_range(32'(2 * TWO_L))) - TWO_L);
        end
        else if (kind >= 7)
        begin
            // angle close to 0, pi or 2pi away; kinds 7, 8 at the tolerance edge
            r.th1 = 32'(longint'($urandom_range(32'(2 * PI_L))) - PI_L);
            off   = longint'($urandom_range(2)) * PI_L
                    + tol_model + $signed($urandom_range(64)) - 32;
            if (kind == 9) off = longint'($urandom_range(2)) * PI_L
                                 + $signed($urandom_range(400000)) - 200000;
            if ($urandom_range(1)) off = -off;
            r.th2 = 32'(longint'(r.th1) + off);
            if (kind == 8)
            begin
                r.rho1 = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                r.rho2 = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        point_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (pending_points.size() == 0)
            begin
                $display("%0t result beat with nothing pending: x %h y %h", $time,
                         x_coord, y_coord);
                err_count++;
            end
            else
            begin
                w = pending_points.pop_front();
                n_par += w.par;
                n_sat += w.sat;
                if (x_coord !== w.x)
                begin
                    $display("%0t x_coord expected %h actual %h", $time, w.x, x_coord);
                    err_count++;
                end
                if (y_coord !== w.y)
                begin
                    $display("%0t y_coord expected %h actual %h", $time, w.y, y_coord);
                    err_count++;
                end
                if (lines_parallel !== w.par)
                begin
                    $display("%0t lines_parallel expected %b actual %b", $time, w.par,
                             lines_parallel);
                    err_count++;
                end
                if (result_saturated !== w.sat)
                begin
                    $display("%0t result_saturated expected %b actual %b", $time, w.sat,
                             result_saturated);
                    err_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < rcv_idle);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Let the pipeline empty before touching the tolerance register
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tol_model  = longint'(v);
    endtask

    // ------------------------------------------------------------------------
    // Directed table, reset tolerance (0.0001 rad = 26844)
    // ------------------------------------------------------------------------
    localparam point_t PAR0 = '{x: '0, y: '0, par: 1'b1, sat: 1'b0};
    localparam logic signed [31:0] ONE_RAD = 32'sd268435456;

    row_t dir_rows[] = '{
        // same angle: all zero, then extreme distances
        '{0, 0, 0, 0, 1, PAR0},
        '{32'sh7FFF_FFFF, ONE_RAD, 32'sh8000_0000, ONE_RAD, 1, PAR0},
        // exactly pi and 2pi apart
        '{32'sd16777216, 0, 32'sd33554432, 32'(PI_L), 1, PAR0},
        '{32'sd5, 32'(-PI_L), 32'sd7, 32'(PI_L), 1, PAR0},
        // one step inside the tolerance, then at it, near 0 and near pi
        '{32'sd100, 0, 32'sd200, 32'sd26843, 1, PAR0},
        '{32'sd100, 0, 32'sd200, 32'sd26844, 0, PAR0},
        '{32'sd100, 0, 32'sd200, 32'(PI_L - 26843), 1, PAR0},
        '{32'sd100, 0, 32'sd200, 32'(PI_L + 26844), 0, PAR0},
        // perpendicular lines
        '{32'sd16777216, 0, 32'sd33554432, 32'(HALF_L), 0, PAR0},
        '{32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'(HALF_L), 0, PAR0},
        '{32'sh8000_0000, 32'(-HALF_L), 32'sh7FFF_FFFF, 32'(PI_L), 0, PAR0},
        // almost parallel, big distances: clamps
        '{32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sd30000, 0, PAR0},
        '{32'sh8000_0000, 32'sd5000, 32'sh7FFF_FFFF, 32'sd35000, 0, PAR0},
        // extreme angles, reduced modulo 2pi
        '{32'sd1000, 32'sh7FFF_FFFF, 32'sd2000, 32'sh8000_0000, 0, PAR0},
        '{32'shFFFF_FFFF, 32'sh8000_0000, 32'sd1, 32'sd0, 0, PAR0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 0, PAR0},
        '{32'sd16777216, 32'(3 * HALF_L), 32'sd16777216, 32'(-3 * HALF_L + 1000), 0,
          PAR0}
    };

    // Phases: tolerance, sender idle %, receiver idle %, beats
    logic [TOL_W-1:0] ph_tol  [N_PHASE];
    int               ph_snd  [N_PHASE] = '{23, 63, 0, 23};
    int               ph_rcv  [N_PHASE] = '{63, 23, 0, 63};
    int               ph_beats[N_PHASE] = '{400, 350, 400, 350};

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        rho_first    = '0;
        theta_first  = '0;
        rho_second   = '0;
        theta_second = '0;
        out_stall    = 1'b0;
        cycles       = 0;
        err_count    = 0;
        beats_in     = 0;
        beats_out    = 0;
        n_par        = 0;
        n_sat        = 0;
        snd_idle     = 23;
        rcv_idle     = 63;
        ph_tol       = '{28'd0, 28'hFFF_FFFF, TOL_RESET, 28'($urandom_range(1, 400000))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_pair(dir_rows[i]);

        for (int p = 0; p < N_PHASE; p++)
        begin
            // sender holds off here until every pending result is back
            drain();
            write_tolerance(ph_tol[p]);
            snd_idle = ph_snd[p];
            rcv_idle = ph_rcv[p];
            for (int n = 0; n < ph_beats[p]; n++)
                send_pair(random_pair());
        end
        drain();

        $display("Checked %0d line pairs against %0d result beats (%0d parallel, %0d clamped)",
                 beats_in, beats_out, n_par, n_sat);
        $display("Tolerance settings: reset, zero, full scale and random; three idle patterns");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
